FILE: hw/rtl/tcp_stream_reassembler_macros.svh
// Assertion macros for the TCP stream reassembler.
`ifndef TCP_STREAM_REASSEMBLER_MACROS_SVH
`define TCP_STREAM_REASSEMBLER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tsr_pkg.sv
// Package: constants and occupancy-map interface types for the stream reassembler.
`timescale 1ns / 1ps
package tsr_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = 32;
	localparam int BYTE_W   = 8;
	localparam int RUN_LEN  = 8;
	localparam int RUN_CW   = $clog2(RUN_LEN + 1);

	typedef struct packed {
		logic              free_en;
		logic [SLOT_W-1:0] free_base;
		logic [CNT_W-1:0]  free_cnt;
		logic              set_en;
		logic [SLOT_W-1:0] set_slot;
		logic [SLOT_W-1:0] probe_slot;
		logic [SLOT_W-1:0] scan_base;
		logic [RUN_CW-1:0] scan_lim;
	} occ_cmd_t;

	typedef struct packed {
		logic              hit;
		logic [RUN_CW-1:0] run;
	} occ_rsp_t;

endpackage

FILE: hw/rtl/tsr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tsr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/tsr_occ.sv
// Slot occupancy map: range free, single set, probe and 8-wide run count.
`timescale 1ns / 1ps
module tsr_occ (
	input  logic              clk,
	input  logic              arst_n,
	input  tsr_pkg::occ_cmd_t cmd,
	output tsr_pkg::occ_rsp_t rsp
);
	import tsr_pkg::*;

	logic [CAPACITY-1:0] occ_q;
	logic [CAPACITY-1:0] free_mask;
	logic [CAPACITY-1:0] set_mask;
	logic [RUN_CW-1:0]   run;

	always_comb begin
		logic [SLOT_W-1:0] off;
		for (int j = 0; j < CAPACITY; j++) begin
			off = SLOT_W'(j) - cmd.free_base;
			free_mask[j] = cmd.free_en && ({1'b0, off} < cmd.free_cnt);
		end
	end

	always_comb begin
		set_mask = '0;
		if (cmd.set_en) begin
			set_mask[cmd.set_slot] = 1'b1;
		end
	end

	// leading run of occupied slots from scan_base, capped at scan_lim
	always_comb begin
		logic              stop;
		logic [SLOT_W-1:0] pos;
		run  = '0;
		stop = 1'b0;
		for (int j = 0; j < RUN_LEN; j++) begin
			pos = cmd.scan_base + SLOT_W'(j);
			if (!stop && (RUN_CW'(j) < cmd.scan_lim) && occ_q[pos]) begin
				run = run + RUN_CW'(1);
			end else begin
				stop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= (occ_q & ~free_mask) | set_mask;
		end
	end

	assign rsp.hit = occ_q[cmd.probe_slot];
	assign rsp.run = run;

endmodule

FILE: hw/rtl/tcp_stream_reassembler.sv
// Top level: out-of-order byte reassembler with a circular window RAM.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  in       | in_valid / in_ready | stream_index, data_byte, has_byte, is_end,
//           |                     | consumer_read_count
//  res      | res_valid/res_ready | out_valid, out_byte, last, stream_ended,
//           |                     | pending_count
//
// An item that assembles nothing passes through accept (frees read slots) and store.
// An item that assembles N bytes passes through accept, store, an occupancy scan at
// 8 slots per cycle, and a finish step; then one byte per cycle off the window RAM
// read port whenever the result register is free.
// Occupancy bits are flops cleared by reset; the byte RAM needs no clearing pass.
// A stalled result beat holds the output register and pauses the RAM reads.
`timescale 1ns / 1ps
`include "tcp_stream_reassembler_macros.svh"
module tcp_stream_reassembler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tsr_pkg::IDX_W-1:0]   stream_index,
	input  logic [tsr_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        has_byte,
	input  logic                        is_end,
	input  logic [tsr_pkg::IDX_W-1:0]   consumer_read_count,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        out_valid,
	output logic [tsr_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last,
	output logic                        stream_ended,
	output logic [tsr_pkg::CNT_W-1:0]   pending_count
);
	import tsr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STORE = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_RES0  = 3'd5;

	localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  rp_q, ap_q, end_idx_q;
	logic              end_known_q, ended_q;
	logic [CNT_W-1:0]  total_q;
	logic [IDX_W-1:0]  idx_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              has_s1;
	logic [SLOT_W-1:0] ep_q;
	logic [CNT_W-1:0]  n_q, lim_q, cnt_q;

	logic              res_valid_q, out_valid_q, last_q, ended_out_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [CNT_W-1:0]  pend_out_q;

	occ_cmd_t          occ_cmd;
	occ_rsp_t          occ_rsp;
	logic              ram_we, ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	logic              accept, out_free, res_load;
	logic [IDX_W-1:0]  adv, span, idx_off, ap_off, ap_fin;
	logic              free_ok, store_ok, walk, ended_now;
	logic [CNT_W-1:0]  free_cnt, total_inc, scan_rem, n_sum, total_fin;
	logic [RUN_CW-1:0] scan_lim;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !res_valid_q || res_ready;

	// a result beat is loaded in these states whenever the output register is free
	assign res_load = out_free && (((state_q == S_STORE) && !walk) || (state_q == S_RES0)
		|| (state_q == S_EMIT));

	// free: consumer progress is honored only within the assembled span
	assign adv      = consumer_read_count - rp_q;
	assign span     = ap_q - rp_q;
	assign free_ok  = accept && (adv <= span);
	assign free_cnt = (adv > CAP_IDX) ? CAP_CNT : adv[CNT_W-1:0];

	// store decision, against the read pointer already advanced
	assign idx_off   = idx_s1 - rp_q;
	assign ap_off    = ap_q - rp_q;
	assign store_ok  = has_s1 && (idx_s1 >= ap_q) && (idx_off < CAP_IDX) && (ap_off < CAP_IDX);
	assign walk      = store_ok && (idx_s1 == ap_q);
	assign total_inc = (store_ok && !occ_rsp.hit) ? total_q + CNT_W'(1) : total_q;
	assign ended_now = ended_q || (end_known_q && (ap_q == end_idx_q));

	assign scan_rem = lim_q - n_q;
	assign scan_lim = (scan_rem >= CNT_W'(RUN_LEN)) ? RUN_CW'(RUN_LEN) : scan_rem[RUN_CW-1:0];
	assign n_sum    = n_q + CNT_W'(occ_rsp.run);

	assign ap_fin    = ap_q + IDX_W'(n_q);
	assign total_fin = (total_q > n_q) ? total_q - n_q : '0;

	always_comb begin
		occ_cmd            = '0;
		occ_cmd.free_en    = free_ok;
		occ_cmd.free_base  = rp_q[SLOT_W-1:0];
		occ_cmd.free_cnt   = free_cnt;
		occ_cmd.set_en     = (state_q == S_STORE) && store_ok;
		occ_cmd.set_slot   = idx_s1[SLOT_W-1:0];
		occ_cmd.probe_slot = idx_s1[SLOT_W-1:0];
		occ_cmd.scan_base  = ep_q + n_q[SLOT_W-1:0];
		occ_cmd.scan_lim   = scan_lim;
	end

	tsr_occ u_occ (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (occ_cmd),
		.rsp    (occ_rsp)
	);

	assign ram_we    = (state_q == S_STORE) && store_ok;
	assign ram_re    = (state_q == S_FIN) || ((state_q == S_EMIT) && out_free && (cnt_q > CNT_W'(1)));
	assign ram_raddr = (state_q == S_FIN) ? ep_q : ep_q + SLOT_W'(1);

	tsr_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (BYTE_W)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1[SLOT_W-1:0]),
		.wdata (byte_s1),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= stream_index;
			byte_s1 <= data_byte;
			has_s1  <= has_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			ap_q        <= '0;
			end_idx_q   <= '0;
			end_known_q <= 1'b0;
			total_q     <= '0;
			ended_q     <= 1'b0;
			ep_q        <= '0;
			n_q         <= '0;
			lim_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_q      <= 1'b0;
			ended_out_q <= 1'b0;
			pend_out_q  <= '0;
		end else begin
			res_valid_q <= res_load || (res_valid_q && !res_ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (free_ok) begin
							rp_q <= consumer_read_count;
						end
						if (is_end) begin
							end_idx_q   <= stream_index + IDX_W'(has_byte);
							end_known_q <= 1'b1;
						end
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					total_q <= total_inc;
					if (walk) begin
						ep_q    <= ap_q[SLOT_W-1:0];
						n_q     <= '0;
						lim_q   <= CAP_CNT - ap_off[CNT_W-1:0];
						state_q <= S_SCAN;
					end else begin
						ended_q <= ended_now;
						if (out_free) begin
							out_valid_q <= 1'b0;
							out_byte_q  <= '0;
							last_q      <= 1'b1;
							ended_out_q <= ended_now;
							pend_out_q  <= total_inc;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_RES0;
						end
					end
				end
				S_RES0: begin
					if (out_free) begin
						out_valid_q <= 1'b0;
						out_byte_q  <= '0;
						last_q      <= 1'b1;
						ended_out_q <= ended_q;
						pend_out_q  <= total_q;
						state_q     <= S_IDLE;
					end
				end
				S_SCAN: begin
					n_q <= n_sum;
					if ((occ_rsp.run < RUN_CW'(RUN_LEN)) || (n_sum == lim_q)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					ap_q    <= ap_fin;
					total_q <= total_fin;
					ended_q <= ended_q || (end_known_q && (ap_fin == end_idx_q));
					cnt_q   <= n_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= ram_rdata;
						last_q      <= (cnt_q == CNT_W'(1));
						ended_out_q <= ended_q;
						pend_out_q  <= total_q;
						cnt_q       <= cnt_q - CNT_W'(1);
						ep_q        <= ep_q + SLOT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last          = last_q;
	assign stream_ended  = ended_out_q;
	assign pending_count = pend_out_q;

	`TSR_ASSERT_IMP(a_span_in_window, clk, arst_n, 1'b1, (ap_q - rp_q) <= CAP_IDX, "assembled span exceeds window")
	`TSR_ASSERT_IMP(a_pending_bound, clk, arst_n, 1'b1, total_q <= CAP_CNT, "pending count exceeds window")
	`TSR_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == S_SCAN, (n_q < lim_q) && (occ_rsp.run <= scan_lim), "scan overran window limit")
	`TSR_ASSERT_NXT(a_fin_reads, clk, arst_n, state_q == S_FIN, (state_q == S_EMIT) && (cnt_q != '0), "assembly finished with no bytes to emit")

endmodule

FILE: tb/sv/tb_tcp_stream_reassembler.sv
// Self-checking testbench for the out-of-order TCP byte stream reassembler.
`timescale 1ns / 1ps

typedef struct packed {
	logic                        valid;
	logic [tsr_pkg::BYTE_W-1:0]  data;
	logic                        last;
	logic                        ended;
	logic [tsr_pkg::CNT_W-1:0]   pending;
} out_beat_t;

// Tracks the reassembly window and queues the result beats each accepted segment must produce.
class stream_window_scoreboard;
	bit [tsr_pkg::BYTE_W-1:0] window_data [tsr_pkg::CAPACITY];
	bit                       slot_taken [tsr_pkg::CAPACITY];
	bit [31:0]                read_ptr;
	bit [31:0]                asm_ptr;
	bit [31:0]                end_idx;
	bit                       end_known;
	bit                       ended;
	int unsigned              unassembled;
	out_beat_t                due_beats [$];
	int                       mismatches;

	function new();
		foreach (slot_taken[i]) begin
			slot_taken[i] = 1'b0;
			window_data[i] = '0;
		end
		read_ptr = '0;
		asm_ptr = '0;
		end_idx = '0;
		end_known = 1'b0;
		ended = 1'b0;
		unassembled = 0;
		mismatches = 0;
	endfunction

	function bit [tsr_pkg::SLOT_W-1:0] slot_of(bit [31:0] pos);
		return tsr_pkg::SLOT_W'(pos % tsr_pkg::CAPACITY);
	endfunction

	function void accept_segment(bit [31:0] idx, bit [7:0] b, bit has, bit eof, bit [31:0] rd);
		bit [31:0] adv;
		bit [31:0] span;
		bit [31:0] ahead;
		bit [31:0] limit;
		out_beat_t beat;
		out_beat_t run [$];
		int i;
		adv = rd - read_ptr;
		span = asm_ptr - read_ptr;
		// a read count outside [read_ptr, asm_ptr] is ignored
		if (adv <= span) begin
			for (i = 0; i < tsr_pkg::CAPACITY && i < adv; i++) begin
				slot_taken[slot_of(read_ptr + i)] = 1'b0;
			end
			read_ptr = rd;
		end
		if (eof) begin
			end_idx = idx + has;
			end_known = 1'b1;
		end
		ahead = idx - read_ptr;
		span = asm_ptr - read_ptr;
		if (has && idx >= asm_ptr && ahead < tsr_pkg::CAPACITY && span < tsr_pkg::CAPACITY) begin
			if (!slot_taken[slot_of(idx)]) begin
				unassembled++;
			end
			window_data[slot_of(idx)] = b;
			slot_taken[slot_of(idx)] = 1'b1;
			if (idx == asm_ptr) begin
				limit = read_ptr + tsr_pkg::CAPACITY;
				while (asm_ptr != limit && run.size() < tsr_pkg::CAPACITY
						&& slot_taken[slot_of(asm_ptr)]) begin
					beat = '0;
					beat.valid = 1'b1;
					beat.data = window_data[slot_of(asm_ptr)];
					run.insert(run.size(), beat);
					asm_ptr++;
					if (unassembled > 0) begin
						unassembled--;
					end
				end
			end
		end
		if (end_known && asm_ptr == end_idx) begin
			ended = 1'b1;
		end
		if (run.size() == 0) begin
			beat = '0;
			run.insert(0, beat);
		end
		foreach (run[k]) begin
			run[k].last = (k == run.size() - 1);
			run[k].ended = ended;
			run[k].pending = tsr_pkg::CNT_W'(unassembled);
			due_beats.insert(due_beats.size(), run[k]);
		end
	endfunction

	function void check_beat(out_beat_t got);
		out_beat_t want;
		if (due_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: result beat with nothing expected: valid=%0b byte=%02h last=%0b",
					$time, got.valid, got.data, got.last);
			end
			return;
		end
		want = due_beats.pop_front();
		if (got.valid !== want.valid || got.data !== want.data || got.last !== want.last
				|| got.ended !== want.ended || got.pending !== want.pending) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: beat mismatch, expected valid=%0b byte=%02h last=%0b ended=%0b pend=%0d",
					$time, want.valid, want.data, want.last, want.ended, want.pending);
				$display("%0t:                  got valid=%0b byte=%02h last=%0b ended=%0b pend=%0d",
					$time, got.valid, got.data, got.last, got.ended, got.pending);
			end
		end
	endfunction
endclass

module tb_tcp_stream_reassembler;
	localparam int CLK_PERIOD      = 8;
	localparam int STALL_LIMIT     = 3000;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 200;
	localparam int RANDOM_SEGMENTS = 140;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [tsr_pkg::IDX_W-1:0]   stream_index;
	logic [tsr_pkg::BYTE_W-1:0]  data_byte;
	logic                        has_byte;
	logic                        is_end;
	logic [tsr_pkg::IDX_W-1:0]   consumer_read_count;
	logic                        res_valid;
	logic                        res_ready;
	logic                        out_valid;
	logic [tsr_pkg::BYTE_W-1:0]  out_byte;
	logic                        last;
	logic                        stream_ended;
	logic [tsr_pkg::CNT_W-1:0]   pending_count;

	stream_window_scoreboard book = new();
	out_beat_t seen_beat;
	int beats_seen = 0;
	int quiet_cycles = 0;
	int send_burst = 0;
	bit held_off = 1'b0;

	tcp_stream_reassembler dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.stream_index        (stream_index),
		.data_byte           (data_byte),
		.has_byte            (has_byte),
		.is_end              (is_end),
		.consumer_read_count (consumer_read_count),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.out_valid           (out_valid),
		.out_byte            (out_byte),
		.last                (last),
		.stream_ended        (stream_ended),
		.pending_count       (pending_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_ready) begin
			seen_beat.valid = out_valid;
			seen_beat.data = out_byte;
			seen_beat.last = last;
			seen_beat.ended = stream_ended;
			seen_beat.pending = pending_count;
			book.check_beat(seen_beat);
			beats_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (res_valid === 1'b1 && res_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL tcp_stream_reassembler");
			$finish;
		end
	end

	// consumer side: random ready with bursts, short stalls and one long hold-off
	initial begin : result_sink
		int roll;
		int stall;
		int streak;
		streak = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && beats_seen >= 60) begin
				held_off = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (streak > 0) begin
				res_ready <= 1'b1;
				streak--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					streak = $urandom_range(20, 50);
					res_ready <= 1'b1;
				end else if (roll < 6) begin
					res_ready <= 1'b0;
					stall = $urandom_range(10, 40);
					repeat (stall) @(negedge clk);
				end else begin
					res_ready <= (roll < 75);
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic offer_segment(bit [31:0] idx, bit [7:0] b, bit has, bit eof, bit [31:0] rd);
		int gap;
		int roll;
		if (send_burst > 0) begin
			gap = 0;
			send_burst--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				send_burst = $urandom_range(20, 40);
				gap = 0;
			end else if (roll < 60) begin
				gap = 0;
			end else if (roll < 90) begin
				gap = $urandom_range(1, 3);
			end else if (roll < 98) begin
				gap = $urandom_range(4, 12);
			end else begin
				gap = $urandom_range(20, 60);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		stream_index <= idx;
		data_byte <= b;
		has_byte <= has;
		is_end <= eof;
		consumer_read_count <= rd;
		do @(posedge clk); while (in_ready !== 1'b1);
		book.accept_segment(idx, b, has, eof, rd);
		@(negedge clk);
	endtask

	function automatic bit [31:0] pick_read(bit lag);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			return $urandom();
		end
		if (roll < 8) begin
			return book.read_ptr - $urandom_range(1, 8);
		end
		if (lag || roll < 30) begin
			return book.read_ptr;
		end
		return $urandom_range(book.read_ptr, book.asm_ptr);
	endfunction

	task automatic noise_item();
		int kind;
		bit [31:0] idx;
		kind = $urandom_range(0, 13);
		case (kind)
			0, 1, 2, 3: begin
				idx = (book.asm_ptr == 0) ? '0 : $urandom_range(0, book.asm_ptr - 1);
				offer_segment(idx, 8'($urandom), 1'b1, 1'b0, pick_read(1'b0));
			end
			4, 5, 6, 7: begin
				idx = $urandom_range(0, 1) ? $urandom()
					: book.read_ptr + tsr_pkg::CAPACITY + $urandom_range(0, 300);
				offer_segment(idx, 8'($urandom), 1'b1, 1'b0, pick_read(1'b0));
			end
			8, 9, 10: begin
				idx = book.asm_ptr + $urandom_range(0, 70);
				offer_segment(idx, 8'($urandom), 1'b0, 1'b0, pick_read(1'b0));
			end
			11, 12: begin
				offer_segment($urandom(), 8'($urandom), 1'($urandom), 1'b0, $urandom());
			end
			default: begin
				// early copy of a byte ahead of the assembly point
				idx = book.asm_ptr + $urandom_range(1, 20);
				offer_segment(idx, 8'($urandom), 1'b1, 1'b0, pick_read(1'b0));
			end
		endcase
	endtask

	// Sends positions base..base+len-1 in shuffled order, noise mixed in.
	// whole: consumer parked at base and the first position sent last, so one beat
	// releases the full window.
	task automatic run_phase(int len, bit lag, bit whole);
		bit [31:0] base;
		int order [$];
		int j;
		int k;
		int t;
		base = book.asm_ptr;
		for (j = whole ? 1 : 0; j < len; j++) begin
			order.insert(order.size(), j);
		end
		for (j = order.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			t = order[j];
			order[j] = order[k];
			order[k] = t;
		end
		if (whole) begin
			order.insert(order.size(), 0);
		end
		for (j = 0; j < order.size(); j++) begin
			if ($urandom_range(0, 3) == 0) begin
				noise_item();
			end
			offer_segment(base + order[j], 8'($urandom), 1'b1, 1'b0,
				whole ? base : pick_read(lag));
		end
	endtask

	task automatic directed_items();
		offer_segment(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd5, 8'h00, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd5, 8'hA5, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd3, 8'h5A, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd0, 8'h77, 1'b0, 1'b0, 32'd0);
		offer_segment(32'd0, 8'h01, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd2, 8'h80, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd1, 8'h7F, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd4, 8'hC3, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd1, 8'h11, 1'b1, 1'b0, 32'd0);
		offer_segment(32'd7, 8'h22, 1'b1, 1'b0, 32'd100);
		offer_segment(32'd8, 8'h33, 1'b1, 1'b0, 32'hFFFF_FFFF);
		offer_segment(32'd9, 8'h44, 1'b1, 1'b0, 32'd3);
		offer_segment(32'd10, 8'h55, 1'b1, 1'b0, 32'd1);
		offer_segment(32'hFFFF_FFF0, 8'h00, 1'b0, 1'b1, 32'd3);
		// end index lands inside the run that this beat releases, so it is stepped over
		offer_segment(32'd6, 8'h66, 1'b1, 1'b1, 32'd6);
		offer_segment(32'd70, 8'h99, 1'b1, 1'b0, 32'd6);
		offer_segment(32'd69, 8'h98, 1'b1, 1'b0, 32'd6);
		offer_segment(32'h8000_0000, 8'hF0, 1'b1, 1'b0, 32'h8000_0000);
		offer_segment(32'd0, 8'h00, 1'b0, 1'b1, 32'd11);
	endtask

	task automatic random_traffic();
		int made;
		int len;
		bit lag;
		bit whole_done;
		bit [31:0] base;
		made = 0;
		lag = 1'b0;
		whole_done = 1'b0;
		while (made < RANDOM_SEGMENTS) begin
			if ($urandom_range(0, 9) == 0) begin
				// end marker far past anything this run reaches
				offer_segment(book.asm_ptr + 32'd5000 + $urandom_range(0, 1000), 8'($urandom),
					1'($urandom), 1'b1, pick_read(lag));
			end
			if (!whole_done && made >= 40) begin
				run_phase(tsr_pkg::CAPACITY, 1'b0, 1'b1);
				// consumer stays parked: window is full and these get dropped
				run_phase(4, 1'b1, 1'b0);
				whole_done = 1'b1;
				made += tsr_pkg::CAPACITY + 4;
			end else begin
				lag = lag ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 3) == 0);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
				run_phase(len, lag, 1'b0);
				made += len;
			end
		end
		// close the stream: end marker first, then the bytes that reach it
		base = book.asm_ptr;
		offer_segment(base + 32'd3, 8'($urandom), 1'b1, 1'b1, base);
		run_phase(3, 1'b0, 1'b0);
		repeat (3) noise_item();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stream_index = '0;
		data_byte = '0;
		has_byte = 1'b0;
		is_end = 1'b0;
		consumer_read_count = '0;
		res_ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_items();
		random_traffic();
		in_valid <= 1'b0;
		while (book.due_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.due_beats.size() == 0) begin
			$display("PASS tcp_stream_reassembler");
		end else begin
			$display("FAIL tcp_stream_reassembler");
		end
		$finish;
	end
endmodule
